>>> rtl/dlphm_pkg.sv
// Shared types, codes and constants of the djb2 linear-probe hash map.
`default_nettype none

package dlphm_pkg;

  // Table geometry defaults
  localparam int unsigned MAX_SLOTS_DEF  = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Field widths fixed by the stream format
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SIZE_W  = 4;

  // djb2 seed and multiply-by-33 shift
  localparam logic [HASH_W-1:0] DJB2_SEED  = 64'd5381;
  localparam int unsigned       DJB2_SHIFT = 5;

  // Slot count register
  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd10;
  localparam logic [SIZE_W-1:0] SIZE_LOG2_MIN = 4'd3;

  // Command queue depth between hashing front and probe engine
  localparam int unsigned CMD_Q_DEPTH = 2;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_GET    = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_UPDATED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Finished key handed from the front to the probe engine
  typedef struct packed {
    logic               func;
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] found_value;
    logic [HASH_W-1:0]  key_hash;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/dlphm_front.sv
// Hashing front: folds key bytes into the djb2 hash and emits a command on the last byte.
`default_nettype none

module dlphm_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              func_i,
  input  wire logic [dlphm_pkg::BYTE_W-1:0]      key_byte_i,
  input  wire logic                              has_byte_i,
  input  wire logic                              last_i,
  input  wire logic [dlphm_pkg::VALUE_W-1:0]     value_i,
  input  wire logic                              hold_i,
  output logic                                   cmd_valid_o,
  input  wire logic                              cmd_ready_i,
  output dlphm_pkg::cmd_t                        cmd_o
);

  logic [dlphm_pkg::HASH_W-1:0] hash_q, hash_d;
  logic [dlphm_pkg::HASH_W-1:0] hash_upd;
  logic                         accept;

  // A last byte needs queue room; other bytes only wait on the clearing pass
  assign in_ready_o = !hold_i && (cmd_ready_i || !last_i);
  assign accept     = in_valid_i && in_ready_o;

  // hash * 33 + byte
  assign hash_upd = has_byte_i
                  ? (hash_q << dlphm_pkg::DJB2_SHIFT) + hash_q
                    + {{(dlphm_pkg::HASH_W - dlphm_pkg::BYTE_W){1'b0}}, key_byte_i}
                  : hash_q;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = last_i ? dlphm_pkg::DJB2_SEED : hash_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= dlphm_pkg::DJB2_SEED;
    end else begin
      hash_q <= hash_d;
    end
  end

  // Command toward the probe engine
  assign cmd_valid_o = accept && last_i;
  assign cmd_o.func  = func_i;
  assign cmd_o.hash  = hash_upd;
  assign cmd_o.value = value_i;

endmodule

`default_nettype wire

>>> rtl/dlphm_cmd_queue.sv
// Small FIFO of finished-key commands between the front and the probe engine.
`default_nettype none

module dlphm_cmd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dlphm_pkg::cmd_t push_data_i,
  output logic                 not_full_o,
  input  wire logic            pop_i,
  output logic                 not_empty_o,
  output dlphm_pkg::cmd_t      pop_data_o
);

  localparam int unsigned Depth = dlphm_pkg::CMD_Q_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dlphm_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign not_full_o  = (count_q != CntW'(Depth));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = entry_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dlphm_probe.sv
// Probe engine: slot memory, clearing pass, linear probing and the result register.
`default_nettype none

module dlphm_probe #(
  parameter int unsigned MAX_SLOTS  = dlphm_pkg::MAX_SLOTS_DEF,
  parameter int unsigned VALUE_BITS = dlphm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [dlphm_pkg::SIZE_W-1:0] size_log2_i,
  output logic                              clearing_o,
  input  wire logic                         cmd_valid_i,
  output logic                              cmd_pop_o,
  input  wire dlphm_pkg::cmd_t              cmd_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output dlphm_pkg::result_t                res_o
);

  localparam int unsigned IdxW   = $clog2(MAX_SLOTS);
  localparam int unsigned CntW   = IdxW + 1;
  localparam int unsigned StoreW = (VALUE_BITS < dlphm_pkg::VALUE_W) ?
                                   VALUE_BITS : dlphm_pkg::VALUE_W;
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_SLOTS - 1);

  // FSM codes
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  typedef struct packed {
    logic                         used;
    logic [dlphm_pkg::HASH_W-1:0] hash;
    logic [StoreW-1:0]            value;
  } slot_t;

  slot_t              mem [MAX_SLOTS];
  slot_t              rdata_q;
  slot_t              wdata;
  logic [IdxW-1:0]    waddr;
  logic               we, re;

  logic [1:0]         state_q, state_d;
  logic [IdxW-1:0]    clr_q;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    mask_q;
  logic [CntW-1:0]    n_q;
  logic [CntW-1:0]    probes_q;
  dlphm_pkg::cmd_t    cur_q;

  logic [dlphm_pkg::SIZE_W-1:0] lg;
  logic [CntW-1:0]    pow_n, n_new;
  logic               hit, empty, last_probe, done, out_free, finish;
  dlphm_pkg::result_t res_q, res_new;
  logic               res_valid_q;

  // Slots in use from the size register, clamped both ways
  always_comb begin
    lg    = (size_log2_i < dlphm_pkg::SIZE_LOG2_MIN) ? dlphm_pkg::SIZE_LOG2_MIN
                                                     : size_log2_i;
    pow_n = CntW'(1) << lg;
    if (32'(lg) >= CntW) begin
      n_new = MaxCnt;
    end else begin
      n_new = (pow_n > MaxCnt) ? MaxCnt : pow_n;
    end
  end

  // Compare against the slot just read
  assign hit        = rdata_q.used && (rdata_q.hash == cur_q.hash);
  assign empty      = !rdata_q.used;
  assign last_probe = (CntW'(probes_q + 1'b1) == n_q);
  assign done       = hit || empty || last_probe;
  assign out_free   = !res_valid_q || res_ready_i;
  assign finish     = (state_q == S_CHECK) && done && out_free;

  // Result of the finished probe walk
  always_comb begin
    res_new             = '0;
    res_new.key_hash    = cur_q.hash;
    if (cur_q.func == dlphm_pkg::FUNC_INSERT) begin
      if (hit) begin
        res_new.status = dlphm_pkg::ST_UPDATED;
      end else if (empty) begin
        res_new.status = dlphm_pkg::ST_INSERTED;
      end else begin
        res_new.status = dlphm_pkg::ST_FULL;
      end
    end else begin
      if (hit) begin
        res_new.status                   = dlphm_pkg::ST_UPDATED;
        res_new.found_value[StoreW-1:0]  = rdata_q.value;
      end else begin
        res_new.status = dlphm_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Memory port control
  always_comb begin
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = '0;
    wdata.used  = 1'b1;
    wdata.hash  = cur_q.hash;
    wdata.value = cur_q.value[StoreW-1:0];
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (finish && (cur_q.func == dlphm_pkg::FUNC_INSERT) && (hit || empty)) begin
      we = 1'b1;
    end
  end
  assign re = (state_q == S_READ);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[idx_q];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == LastIdx) state_d = S_IDLE;
      S_IDLE:  if (cmd_valid_i) state_d = S_READ;
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (!done) begin
          state_d = S_READ;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign clearing_o = (state_q == S_CLEAR);

  // Command and probe registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q    <= cmd_i;
      n_q      <= n_new;
      mask_q   <= IdxW'(n_new - 1'b1);
      idx_q    <= cmd_i.hash[IdxW-1:0] & IdxW'(n_new - 1'b1);
      probes_q <= '0;
    end else if ((state_q == S_CHECK) && !done) begin
      idx_q    <= IdxW'(idx_q + 1'b1) & mask_q;
      probes_q <= probes_q + 1'b1;
    end
    if (finish) begin
      res_q <= res_new;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (finish) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> rtl/djb2_linear_probe_hash_map.sv
// Top level of the djb2 linear-probe hash map.
//
// Key bytes enter one per cycle while s_axis_tready is high (it drops during
// the clearing pass, and for a last byte while the command queue is full) and
// fold into a 64-bit djb2 hash; the transaction with tlast set queues the
// finished key for an insert or get, and the hashing front keeps taking bytes
// of the next key meanwhile. The probe engine starts a command from idle and
// probes each slot with one registered memory read and one compare; a walk
// ends at a hit, an empty slot or the last of the slots in use. After reset
// the engine clears the slot memory one entry per cycle with s_axis_tready low;
// size_log2 writes are taken at any time and must only change while the block is idle.
`default_nettype none

module djb2_linear_probe_hash_map #(
  parameter int unsigned MAX_SLOTS  = dlphm_pkg::MAX_SLOTS_DEF,
  parameter int unsigned VALUE_BITS = dlphm_pkg::VALUE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // size_log2 register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_size_log2_i,
  // key bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // key_byte[7:0], value[39:8]
  input  wire logic [1:0]  s_axis_tuser,   // func[0], has_byte[1]
  input  wire logic        s_axis_tlast,   // last
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // found_value[31:0], key_hash[95:32]
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  logic [dlphm_pkg::SIZE_W-1:0] size_log2_q;
  logic                         clearing;
  logic                         push, q_not_full, q_not_empty, pop;
  dlphm_pkg::cmd_t              push_cmd, pop_cmd;
  dlphm_pkg::result_t           res;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= dlphm_pkg::SIZE_LOG2_RST;
    end else if (cfg_valid_i) begin
      size_log2_q <= cfg_size_log2_i;
    end
  end

  dlphm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser[0]),
    .key_byte_i  (s_axis_tdata[7:0]),
    .has_byte_i  (s_axis_tuser[1]),
    .last_i      (s_axis_tlast),
    .value_i     (s_axis_tdata[39:8]),
    .hold_i      (clearing),
    .cmd_valid_o (push),
    .cmd_ready_i (q_not_full),
    .cmd_o       (push_cmd)
  );

  dlphm_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .not_full_o  (q_not_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (pop_cmd)
  );

  dlphm_probe #(
    .MAX_SLOTS  (MAX_SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_log2_i (size_log2_q),
    .clearing_o  (clearing),
    .cmd_valid_i (q_not_empty),
    .cmd_pop_o   (pop),
    .cmd_i       (pop_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Result packing
  assign m_axis_tdata = {res.key_hash, res.found_value};
  assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

>>> rtl/dlphm_checker.sv
// Port-level checker for the hash map, bound to the top level.
`default_nettype none

module dlphm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only a successful get carries a nonzero value
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[31:0] != 32'd0) |->
      m_axis_tuser == dlphm_pkg::ST_UPDATED)
    else $error("found value on a result other than a hit");

  // Clearing pass keeps the input closed right after reset
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input open before the slot memory was cleared");

  // No result can exist in the first cycle after reset
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind djb2_linear_probe_hash_map dlphm_checker u_dlphm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/djb2_linear_probe_hash_map_tb.sv
// Self-checking testbench for the djb2 linear-probe hash map: directed tests, then random keys.
`default_nettype none

module djb2_linear_probe_hash_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Key bytes of one key, first byte in b[0]
  typedef struct packed {
    logic [4:0]       len;
    logic [15:0][7:0] b;
  } key_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_size_log2_i = dlphm_pkg::SIZE_LOG2_RST;
  logic        s_axis_tvalid   = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata    = '0;  // key_byte[7:0], value[39:8]
  logic [1:0]  s_axis_tuser    = '0;  // func[0], has_byte[1]
  logic        s_axis_tlast    = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready   = 1'b0;
  logic [95:0] m_axis_tdata;          // found_value[31:0], key_hash[95:32]
  logic [1:0]  m_axis_tuser;          // status[1:0]

  // Shadow of the table and the hashing front
  logic [63:0] run_hash;
  logic [63:0] shadow_hash [dlphm_pkg::MAX_SLOTS_DEF];
  logic [31:0] shadow_value[dlphm_pkg::MAX_SLOTS_DEF];
  bit          shadow_used [dlphm_pkg::MAX_SLOTS_DEF];
  logic [3:0]  shadow_size_log2;

  dlphm_pkg::result_t pending[$];   // results still owed by the block, oldest first
  key_t    key_pool[$];  // keys seen so far, reused to hit stored entries
  int      errors     = 0;
  int      items_sent = 0;
  bit      quiet      = 1'b0;  // no idling on either side
  bit      noise_on   = 1'b0;  // sprinkle no-byte transactions into keys

  djb2_linear_probe_hash_map uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_size_log2_i (cfg_size_log2_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #150_000_000;
    $display("djb2_linear_probe_hash_map_tb: FAIL");
    $finish;
  end

  // Shadow state after reset
  initial begin : shadow_init
    run_hash         = dlphm_pkg::DJB2_SEED;
    shadow_size_log2 = dlphm_pkg::SIZE_LOG2_RST;
    for (int i = 0; i < dlphm_pkg::MAX_SLOTS_DEF; i++) begin
      shadow_hash[i]  = '0;
      shadow_value[i] = '0;
      shadow_used[i]  = 1'b0;
    end
  end

  // Fold one byte transaction into the hash; on the last byte run the lookup
  function automatic void hash_and_probe(input logic func, input logic [7:0] kb,
                                         input logic has, input logic lst,
                                         input logic [31:0] val);
    logic [63:0] h;
    int unsigned lg, n, mask, idx;
    bit          hit, vacant;
    dlphm_pkg::result_t r;
    if (has) run_hash = (run_hash << dlphm_pkg::DJB2_SHIFT) + run_hash + 64'(kb);
    if (!lst) return;
    h        = run_hash;
    run_hash = dlphm_pkg::DJB2_SEED;
    lg = 32'(shadow_size_log2);
    if (lg < 32'(dlphm_pkg::SIZE_LOG2_MIN)) lg = 32'(dlphm_pkg::SIZE_LOG2_MIN);
    n = 1 << lg;
    if (n > dlphm_pkg::MAX_SLOTS_DEF) n = dlphm_pkg::MAX_SLOTS_DEF;
    mask   = n - 1;
    idx    = h[31:0] & mask;
    hit    = 1'b0;
    vacant = 1'b0;
    // linear probe, wrapping inside the slots in use
    for (int unsigned p = 0; p < n; p++) begin
      if (!shadow_used[idx]) begin
        vacant = 1'b1;
        break;
      end
      if (shadow_hash[idx] == h) begin
        hit = 1'b1;
        break;
      end
      idx = (idx + 1) & mask;
    end
    r.key_hash    = h;
    r.found_value = '0;
    if (func == dlphm_pkg::FUNC_INSERT) begin
      if (hit || vacant) begin
        shadow_used[idx]  = 1'b1;
        shadow_hash[idx]  = h;
        shadow_value[idx] = val;
        r.status = hit ? dlphm_pkg::ST_UPDATED : dlphm_pkg::ST_INSERTED;
      end else begin
        r.status = dlphm_pkg::ST_FULL;
      end
    end else if (hit) begin
      r.status      = dlphm_pkg::ST_UPDATED;
      r.found_value = shadow_value[idx];
    end else begin
      r.status = dlphm_pkg::ST_NOT_FOUND;
    end
    pending.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    // keep the log short if the block is badly broken
    if (errors < 100) $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // Result check; the handshake edge follows this sample point
  always @(negedge clk_i) begin : result_check
    dlphm_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        report_mismatch("result with none pending, key_hash", m_axis_tdata[95:32], '0);
      end else begin
        want = pending.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        if (m_axis_tdata[31:0] !== want.found_value)
          report_mismatch("found_value", 64'(m_axis_tdata[31:0]), 64'(want.found_value));
        if (m_axis_tdata[95:32] !== want.key_hash)
          report_mismatch("key_hash", m_axis_tdata[95:32], want.key_hash);
      end
    end
  end

  // Result side: random stall before each transaction
  initial begin : result_sink
    int stall;
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  // One byte transaction; tvalid stays high if the next one follows at once
  task automatic send_item(input logic func, input logic [7:0] kb, input logic has,
                           input logic lst, input logic [31:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, kb};
    s_axis_tuser  <= {has, func};
    s_axis_tlast  <= lst;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    hash_and_probe(func, kb, has, lst, val);
    items_sent++;
  endtask

  // Whole key; func and value only matter on the last byte
  task automatic send_key(input logic func, input key_t k, input logic [31:0] val);
    if (k.len == 0) begin
      send_item(func, 8'($urandom_range(0, 255)), 1'b0, 1'b1, val);
    end else begin
      for (int i = 0; i < k.len; i++) begin
        if (noise_on && $urandom_range(0, 9) == 0)
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                    $urandom);
        if (i == k.len - 1) send_item(func, k.b[i], 1'b1, 1'b1, val);
        else send_item(1'($urandom_range(0, 1)), k.b[i], 1'b1, 1'b0, $urandom);
      end
    end
  endtask

  function automatic key_t short_key(input int unsigned n, input logic [7:0] b0 = 8'h00,
                                     input logic [7:0] b1 = 8'h00);
    key_t k;
    k      = '0;
    k.len  = 5'(n);
    k.b[0] = b0;
    k.b[1] = b1;
    return k;
  endfunction

  // Size write, only once the block has drained
  task automatic write_size(input logic [3:0] lg);
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_size_log2_i <= lg;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i      <= 1'b0;
    shadow_size_log2 = lg;
  endtask

  // Insert, get, update, empty keys and byte-less transactions at reset size
  task automatic test_basic_ops();
    send_key(dlphm_pkg::FUNC_GET, short_key(0), $urandom);
    send_key(dlphm_pkg::FUNC_INSERT, short_key(0), 32'hFFFF_FFFF);
    send_key(dlphm_pkg::FUNC_GET, short_key(0), 32'h0);
    send_key(dlphm_pkg::FUNC_INSERT, short_key(1, 8'h00), 32'h0);
    send_key(dlphm_pkg::FUNC_INSERT, short_key(2, 8'hFF, 8'hFF), 32'h8000_0001);
    send_key(dlphm_pkg::FUNC_GET, short_key(2, 8'hFF, 8'hFF), $urandom);
    // no-byte transaction inside a key leaves the hash alone
    send_item(dlphm_pkg::FUNC_GET, 8'h41, 1'b1, 1'b0, $urandom);
    send_item(dlphm_pkg::FUNC_GET, 8'hA5, 1'b0, 1'b0, $urandom);
    send_item(dlphm_pkg::FUNC_INSERT, 8'h42, 1'b1, 1'b1, 32'h1234_5678);
    send_key(dlphm_pkg::FUNC_GET, short_key(2, 8'h41, 8'h42), $urandom);
    // last without a byte works on the hash so far
    send_item(dlphm_pkg::FUNC_INSERT, 8'h43, 1'b1, 1'b0, $urandom);
    send_item(dlphm_pkg::FUNC_GET, 8'h5A, 1'b0, 1'b1, $urandom);
    send_key(dlphm_pkg::FUNC_INSERT, short_key(2, 8'hFF, 8'hFF), 32'h0);
  endtask

  // Key whose hash wraps to zero: 13 base-33 digits cancel seed*33^13
  task automatic test_zero_hash();
    logic [63:0] pw, x;
    key_t        k;
    pw = 64'd1;
    repeat (13) pw = pw * 64'd33;
    x = -(dlphm_pkg::DJB2_SEED * pw);
    k = '0;
    k.len = 5'd13;
    for (int i = 12; i >= 0; i--) begin
      k.b[i] = 8'(x % 64'd33);
      x      = x / 64'd33;
    end
    send_key(dlphm_pkg::FUNC_INSERT, k, 32'h0BAD_F00D);
    send_key(dlphm_pkg::FUNC_GET, k, $urandom);
  endtask

  // Smallest table: overflow on insert, full walk on get
  task automatic test_full_table();
    write_size(4'd0);
    for (int i = 0; i < 10; i++)
      send_key(dlphm_pkg::FUNC_INSERT, short_key(1, 8'(8'h10 + i)), $urandom);
    send_key(dlphm_pkg::FUNC_GET, short_key(1, 8'h7E), $urandom);
    send_key(dlphm_pkg::FUNC_GET, short_key(1, 8'h10), $urandom);
  endtask

  // Entries stay where they are across size changes
  task automatic test_resize_keeps_entries();
    write_size(4'd15);
    send_key(dlphm_pkg::FUNC_GET, short_key(2, 8'hFF, 8'hFF), $urandom);
    send_key(dlphm_pkg::FUNC_GET, short_key(0), $urandom);
    write_size(4'd3);
    send_key(dlphm_pkg::FUNC_GET, short_key(1, 8'h10), $urandom);
    send_key(dlphm_pkg::FUNC_GET, short_key(2, 8'hFF, 8'hFF), $urandom);
  endtask

  // Random keys in phases of different table sizes, some without idling
  task automatic test_random_traffic();
    logic [3:0] sizes[8] = '{4'd10, 4'd3, 4'd5, 4'd10, 4'd4, 4'd8, 4'd3, 4'd6};
    key_t       k;
    int         phase_end;
    noise_on = 1'b1;
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      quiet     = (p % 3 == 1);
      phase_end = items_sent + 130;
      while (items_sent < phase_end) begin
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 45) begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
          k     = '0;
          k.len = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 6));
          for (int i = 0; i < k.len; i++) k.b[i] = 8'($urandom_range(0, 255));
          if (key_pool.size() < 64) key_pool.push_back(k);
          else key_pool[$urandom_range(0, 63)] = k;
        end
        send_key(1'($urandom_range(0, 1)), k, $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_zero_hash();
    test_full_table();
    test_resize_keeps_entries();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (errors == 0) begin
      $display("djb2_linear_probe_hash_map_tb: PASS");
    end else begin
      $display("djb2_linear_probe_hash_map_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
